// ===== hdl/kdlt_pkg.sv =====
// ----------------------------------------------------------------------------
// kdlt_pkg
// Shared constants and request/result types for the key digraph latency table.
// ----------------------------------------------------------------------------
package kdlt_pkg;

  localparam int KIND_W  = 2;
  localparam int KEY_W   = 8;
  localparam int TS_W    = 48;
  localparam int MEAN_W  = 40;
  localparam int CNT_W   = 16;
  localparam int LIMIT_W = 32;

  localparam int KEY_COUNT_DEF      = 256;
  localparam int COUNT_BITS_DEF     = 16;
  localparam int MEAN_FRAC_BITS_DEF = 8;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 32'd1000000;

  localparam logic [KIND_W-1:0] KIND_PRESS = 2'd0;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd2;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [KEY_W-1:0]  key_code;
    logic [KEY_W-1:0]  other_key;
    logic [TS_W-1:0]   timestamp_us;
    logic [MEAN_W-1:0] entry_mean;
    logic [CNT_W-1:0]  entry_count;
  } kdlt_in_t;

  typedef struct packed {
    logic              counted;
    logic [TS_W-1:0]   interval_us;
    logic [MEAN_W-1:0] mean_value;
    logic [CNT_W-1:0]  count_value;
  } kdlt_out_t;

endpackage

// ===== hdl/kdlt_if.sv =====
// ----------------------------------------------------------------------------
// kdlt_if
// Valid/ready channels carrying requests into and results out of the table.
// ----------------------------------------------------------------------------
interface kdlt_in_if import kdlt_pkg::*; ();
  logic     valid;
  logic     ready;
  kdlt_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface kdlt_out_if import kdlt_pkg::*; ();
  logic      valid;
  logic      ready;
  kdlt_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== hdl/kdlt_ram.sv =====
// ----------------------------------------------------------------------------
// kdlt_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module kdlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/kdlt_mean_unit.sv =====
// ----------------------------------------------------------------------------
// kdlt_mean_unit
// Running-mean update: increments the count with saturation, forms
// mean*(n-1)+interval in two partial products and divides by n one quotient
// bit per cycle, saturating the mean to its field width.
// ----------------------------------------------------------------------------
module kdlt_mean_unit import kdlt_pkg::*; #(
  parameter int COUNT_BITS     = COUNT_BITS_DEF,
  parameter int MEAN_FRAC_BITS = MEAN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [MEAN_W-1:0]     mean_in,
  input  logic [COUNT_BITS-1:0] count_in,
  input  logic [LIMIT_W-1:0]    interval_in,
  output logic                  done,
  output logic [MEAN_W-1:0]     mean_out,
  output logic [COUNT_BITS-1:0] count_out
);

  localparam int LO_W   = 32;
  localparam int ADD_W  = LIMIT_W + MEAN_FRAC_BITS;
  localparam int PROD_W = MEAN_W + COUNT_BITS;
  localparam int NUM_W  = ((PROD_W > ADD_W) ? PROD_W : ADD_W) + 1;
  localparam int HI_W   = NUM_W - MEAN_W;
  localparam int P0_W   = LO_W + COUNT_BITS;
  localparam int P1_W   = (MEAN_W - LO_W) + COUNT_BITS;
  localparam int STEP_W = $clog2(MEAN_W);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL0 = 3'd1;
  localparam logic [2:0] ST_MUL1 = 3'd2;
  localparam logic [2:0] ST_SUM  = 3'd3;
  localparam logic [2:0] ST_DIV  = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]            state_r, state_nxt;
  logic [MEAN_W-1:0]     mean_r, mean_nxt;
  logic [COUNT_BITS-1:0] n_r, n_nxt;
  logic [COUNT_BITS-1:0] m1_r, m1_nxt;
  logic [ADD_W-1:0]      add_r, add_nxt;
  logic [P0_W-1:0]       p0_r, p0_nxt;
  logic [P1_W-1:0]       p1_r, p1_nxt;
  logic [NUM_W-1:0]      acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [MEAN_W-1:0]     q_r, q_nxt;
  logic [STEP_W-1:0]     step_r, step_nxt;

  logic [NUM_W-1:0]      num;
  logic                  sat;
  logic [COUNT_BITS:0]   trial;
  logic [COUNT_BITS:0]   diff;
  logic                  ge;
  logic                  at_max;

  always_comb begin
    at_max = (count_in == {COUNT_BITS{1'b1}});
    num    = acc_r + (NUM_W'(p1_r) << LO_W);
    sat    = (num[NUM_W-1:MEAN_W] >= HI_W'(n_r));
    trial  = {rem_r, q_r[MEAN_W-1]};
    diff   = trial - {1'b0, n_r};
    ge     = (trial >= {1'b0, n_r});

    state_nxt = state_r;
    mean_nxt  = mean_r;
    n_nxt     = n_r;
    m1_nxt    = m1_r;
    add_nxt   = add_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    q_nxt     = q_r;
    step_nxt  = step_r;

    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          mean_nxt  = mean_in;
          n_nxt     = at_max ? count_in : count_in + COUNT_BITS'(1);
          m1_nxt    = at_max ? count_in - COUNT_BITS'(1) : count_in;
          add_nxt   = ADD_W'(interval_in) << MEAN_FRAC_BITS;
          state_nxt = ST_MUL0;
        end
      end
      ST_MUL0: begin
        p0_nxt    = P0_W'(mean_r[LO_W-1:0]) * P0_W'(m1_r);
        state_nxt = ST_MUL1;
      end
      ST_MUL1: begin
        p1_nxt    = P1_W'(mean_r[MEAN_W-1:LO_W]) * P1_W'(m1_r);
        acc_nxt   = NUM_W'(p0_r) + NUM_W'(add_r);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        rem_nxt  = num[MEAN_W +: COUNT_BITS];
        step_nxt = '0;
        if (sat) begin
          q_nxt     = {MEAN_W{1'b1}};
          state_nxt = ST_DONE;
        end else begin
          q_nxt     = num[MEAN_W-1:0];
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        rem_nxt  = ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
        q_nxt    = {q_r[MEAN_W-2:0], ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(MEAN_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    mean_r <= mean_nxt;
    n_r    <= n_nxt;
    m1_r   <= m1_nxt;
    add_r  <= add_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    acc_r  <= acc_nxt;
    rem_r  <= rem_nxt;
    q_r    <= q_nxt;
    step_r <= step_nxt;
  end

  assign done      = (state_r == ST_DONE);
  assign mean_out  = q_r;
  assign count_out = n_r;

  a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> state_r == ST_IDLE)
    else $error("mean update started while busy");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < n_r)
    else $error("partial remainder not below divisor");

  a_done_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> count_out != '0)
    else $error("updated entry has zero count");

endmodule

// ===== hdl/key_digraph_latency_table_core.sv =====
// ----------------------------------------------------------------------------
// key_digraph_latency_table_core
// Per key-pair count and running mean of the interval between key presses.
// ----------------------------------------------------------------------------
// After reset the block clears all KEY_COUNT*KEY_COUNT entries of the table
// memory (65536 by default), during which no request is taken; the interval
// limit may be written at any time the block is idle. A press that updates an
// entry waits on the bit-serial divider of the mean unit, which produces one
// of the 40 mean bits per cycle; an update whose mean saturates skips the
// divider. A press that is not counted and a table read pass through the
// memory's registered read port before the result is formed, and a write or
// an unused kind goes straight to the result. One request is in progress at a
// time: the next can be taken in the same cycle as the result is presented,
// and a finished result waits in the output register while the next request
// is taken; a new result enters it only once the previous one has left it.
// ----------------------------------------------------------------------------
module key_digraph_latency_table_core import kdlt_pkg::*; #(
  parameter int KEY_COUNT      = KEY_COUNT_DEF,
  parameter int COUNT_BITS     = COUNT_BITS_DEF,
  parameter int MEAN_FRAC_BITS = MEAN_FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  kdlt_in_if.sink            in_req,
  kdlt_out_if.source         out_rsp,
  input  logic               cfg_we,
  input  logic [LIMIT_W-1:0] cfg_wdata
);

  localparam int KB        = $clog2(KEY_COUNT);
  localparam int DEPTH     = KEY_COUNT * KEY_COUNT;
  localparam int ADDR_W    = $clog2(DEPTH);
  localparam int ENTRY_W   = MEAN_W + COUNT_BITS;
  localparam int KEY_RANGE = 2 ** KEY_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_MEAN = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [KB-1:0] key_lut [KEY_RANGE];

  for (genvar gi = 0; gi < KEY_RANGE; gi++) begin : g_key_lut
    assign key_lut[gi] = KB'(gi % KEY_COUNT);
  end

  logic [1:0]            state_r, state_nxt;
  logic                  clr_r, clr_nxt;
  logic [ADDR_W-1:0]     clr_addr_r, clr_addr_nxt;
  logic [LIMIT_W-1:0]    limit_r, limit_nxt;
  logic [KEY_W-1:0]      prev_key_r, prev_key_nxt;
  logic [TS_W-1:0]       prev_time_r, prev_time_nxt;
  logic [KIND_W-1:0]     kind_r, kind_nxt;
  logic [ADDR_W-1:0]     idx_r, idx_nxt;
  logic [TS_W-1:0]       interval_r, interval_nxt;
  logic                  counted_r, counted_nxt;
  logic [MEAN_W-1:0]     res_mean_r, res_mean_nxt;
  logic [COUNT_BITS-1:0] res_count_r, res_count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  kdlt_out_t             out_data_r, out_data_nxt;

  kdlt_in_t              req;
  logic                  accept;
  logic [KB-1:0]         row;
  logic [KB-1:0]         col;
  logic [ADDR_W-1:0]     idx;
  logic [TS_W-1:0]       gap;
  logic                  hit;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ENTRY_W-1:0]    ram_wdata;
  logic [ENTRY_W-1:0]    ram_rdata;

  logic                  mu_start;
  logic                  mu_done;
  logic [MEAN_W-1:0]     mu_mean;
  logic [COUNT_BITS-1:0] mu_count;

  assign req          = in_req.data;
  assign in_req.ready = (state_r == S_IDLE) && !clr_r;
  assign accept       = in_req.valid && in_req.ready;

  always_comb begin
    row = key_lut[req.key_code];
    col = (req.kind == KIND_PRESS) ? key_lut[prev_key_r] : key_lut[req.other_key];
    idx = ADDR_W'(row) * ADDR_W'(KEY_COUNT) + ADDR_W'(col);
    gap = (req.timestamp_us >= prev_time_r) ? req.timestamp_us - prev_time_r : '0;
    hit = (kind_r == KIND_PRESS) && (interval_r < TS_W'(limit_r));
  end

  assign mu_start = (state_r == S_RD) && hit;

  always_comb begin
    priority if (clr_r) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (accept && req.kind == KIND_WRITE) begin
      ram_we    = 1'b1;
      ram_waddr = idx;
      ram_wdata = {req.entry_mean, COUNT_BITS'(req.entry_count)};
    end else if (state_r == S_MEAN && mu_done) begin
      ram_we    = 1'b1;
      ram_waddr = idx_r;
      ram_wdata = {mu_mean, mu_count};
    end else begin
      ram_we    = 1'b0;
      ram_waddr = idx_r;
      ram_wdata = {mu_mean, mu_count};
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    clr_addr_nxt  = clr_addr_r;
    limit_nxt     = cfg_we ? cfg_wdata : limit_r;
    prev_key_nxt  = prev_key_r;
    prev_time_nxt = prev_time_r;
    kind_nxt      = kind_r;
    idx_nxt       = idx_r;
    interval_nxt  = interval_r;
    counted_nxt   = counted_r;
    res_mean_nxt  = res_mean_r;
    res_count_nxt = res_count_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    out_data_nxt  = out_data_r;

    if (clr_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_nxt = 1'b0;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt      = req.kind;
          idx_nxt       = idx;
          interval_nxt  = '0;
          counted_nxt   = 1'b0;
          res_mean_nxt  = '0;
          res_count_nxt = '0;
          unique case (req.kind)
            KIND_PRESS: begin
              interval_nxt  = gap;
              prev_key_nxt  = req.key_code;
              prev_time_nxt = req.timestamp_us;
              state_nxt     = S_RD;
            end
            KIND_READ: begin
              state_nxt = S_RD;
            end
            KIND_WRITE: begin
              res_mean_nxt  = req.entry_mean;
              res_count_nxt = COUNT_BITS'(req.entry_count);
              state_nxt     = S_OUT;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_RD: begin
        if (hit) begin
          counted_nxt = 1'b1;
          state_nxt   = S_MEAN;
        end else begin
          res_mean_nxt  = ram_rdata[ENTRY_W-1:COUNT_BITS];
          res_count_nxt = ram_rdata[COUNT_BITS-1:0];
          state_nxt     = S_OUT;
        end
      end
      S_MEAN: begin
        if (mu_done) begin
          res_mean_nxt  = mu_mean;
          res_count_nxt = mu_count;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.counted     = counted_r;
          out_data_nxt.interval_us = interval_r;
          out_data_nxt.mean_value  = res_mean_r;
          out_data_nxt.count_value = CNT_W'(res_count_r);
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      clr_r       <= 1'b1;
      clr_addr_r  <= '0;
      limit_r     <= LIMIT_RESET;
      prev_key_r  <= '0;
      prev_time_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      clr_addr_r  <= clr_addr_nxt;
      limit_r     <= limit_nxt;
      prev_key_r  <= prev_key_nxt;
      prev_time_r <= prev_time_nxt;
      out_valid_r <= out_valid_nxt;
    end
    kind_r      <= kind_nxt;
    idx_r       <= idx_nxt;
    interval_r  <= interval_nxt;
    counted_r   <= counted_nxt;
    res_mean_r  <= res_mean_nxt;
    res_count_r <= res_count_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_rsp.valid = out_valid_r;
  assign out_rsp.data  = out_data_r;

  kdlt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (idx),
    .rd_data (ram_rdata)
  );

  kdlt_mean_unit #(
    .COUNT_BITS     (COUNT_BITS),
    .MEAN_FRAC_BITS (MEAN_FRAC_BITS)
  ) u_mean (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (mu_start),
    .mean_in     (ram_rdata[ENTRY_W-1:COUNT_BITS]),
    .count_in    (ram_rdata[COUNT_BITS-1:0]),
    .interval_in (interval_r[LIMIT_W-1:0]),
    .done        (mu_done),
    .mean_out    (mu_mean),
    .count_out   (mu_count)
  );

  a_rsp_held: assert property (@(posedge clk) disable iff (!rst_n)
    out_rsp.valid && !out_rsp.ready |=> out_rsp.valid && $stable(out_rsp.data))
    else $error("waiting result changed before it was taken");

  a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_req.ready)
    else $error("request taken while the table was being cleared");

  a_mean_done_in_mean_state: assert property (@(posedge clk) disable iff (!rst_n)
    mu_done |-> state_r == S_MEAN)
    else $error("mean update finished outside the mean state");

endmodule
